// ----- rtl/bole_pkg.sv -----
// Shared types and constants for the bounded ordered list engine.
package bole_pkg;

   // Storage size and derived widths
   localparam int Capacity = 16;
   localparam int CountW   = $clog2(Capacity + 1);
   localparam int ValueW   = 32;

   // Operation codes
   localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
   localparam logic [2:0] ACT_SORTED_INS = 3'd2;
   localparam logic [2:0] ACT_POP_FRONT  = 3'd3;
   localparam logic [2:0] ACT_POP_BACK   = 3'd4;
   localparam logic [2:0] ACT_REMOVE     = 3'd5;
   localparam logic [2:0] ACT_SEARCH     = 3'd6;

   // Result status codes
   localparam logic [1:0] STS_DONE  = 2'd0;
   localparam logic [1:0] STS_EMPTY = 2'd1;
   localparam logic [1:0] STS_FULL  = 2'd2;
   localparam logic [1:0] STS_MISS  = 2'd3;

   typedef struct packed {
      logic [2:0]               action;
      logic signed [ValueW-1:0] operand_value;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic              found;
      logic [CountW-1:0] entry_count;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;    // capture operation and cell compares
      logic commit;  // update cells and response register
   } cmd_type;

endpackage

// ----- rtl/bole_ctrl.sv -----
// Controller: sequences capture and commit, owns both handshakes.
module bole_ctrl import bole_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_APPLY = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // response register can take a new result
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // response valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/bole_datapath.sv -----
// Datapath: row of value cells with parallel compare and one-step shift.
module bole_datapath import bole_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  req_type req_data,
   output rsp_type rsp_data
);

   logic signed [ValueW-1:0] cell_ff [Capacity];
   logic signed [ValueW-1:0] cell_in [Capacity];
   logic [CountW-1:0]        count_ff, count_in;
   logic [2:0]               action_ff;
   logic signed [ValueW-1:0] value_ff;
   logic [Capacity-1:0]      lt_ff, eq_ff;
   logic [Capacity-1:0]      lt_in, eq_in, valid;
   rsp_type                  rsp_ff, rsp_in;

   logic                is_full, is_empty, any_eq;
   logic [Capacity-1:0] stop, after, pos;
   logic                do_ins, do_rm, do_pop_back;

   // cell occupancy and parallel compares against the incoming value
   always_comb begin
      for (int i = 0; i < Capacity; i++) begin
         valid[i] = (CountW'(i) < count_ff);
         lt_in[i] = valid[i] && (cell_ff[i] < req_data.operand_value);
         eq_in[i] = valid[i] && (cell_ff[i] == req_data.operand_value);
      end
   end

   assign is_full  = (count_ff == CountW'(Capacity));
   assign is_empty = (count_ff == '0);
   assign any_eq   = |eq_ff;

   // decide operation, status and occupancy
   always_comb begin
      do_ins      = 1'b0;
      do_rm       = 1'b0;
      do_pop_back = 1'b0;
      stop        = '0;
      rsp_in      = '0;
      case (action_ff)
         ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_SORTED_INS: begin
            if (is_full) begin
               rsp_in.status = STS_FULL;
            end else begin
               do_ins = 1'b1;
            end
            if (action_ff == ACT_PUSH_FRONT) begin
               stop = Capacity'(1);
            end else if (action_ff == ACT_PUSH_BACK) begin
               stop = ~valid;
            end else begin
               stop = ~lt_ff;
            end
         end
         ACT_POP_FRONT, ACT_POP_BACK: begin
            if (is_empty) begin
               rsp_in.status = STS_EMPTY;
            end else if (action_ff == ACT_POP_FRONT) begin
               do_rm = 1'b1;
            end else begin
               do_pop_back = 1'b1;
            end
            stop = Capacity'(1);
         end
         ACT_REMOVE, ACT_SEARCH: begin
            rsp_in.found = any_eq;
            if (!any_eq) begin
               rsp_in.status = STS_MISS;
            end else if (action_ff == ACT_REMOVE) begin
               do_rm = 1'b1;
            end
            stop = eq_ff;
         end
         default: ;
      endcase
      // occupancy update
      count_in = count_ff;
      if (do_ins) begin
         count_in = count_ff + CountW'(1);
      end else if (do_rm || do_pop_back) begin
         count_in = count_ff - CountW'(1);
      end
      rsp_in.entry_count = count_in;
   end

   // lowest stop bit and every cell from it upward
   assign pos   = stop & (-stop);
   assign after = stop | (-stop);

   // next cell contents: open or close a slot in one step
   always_comb begin
      for (int i = 0; i < Capacity; i++) begin
         cell_in[i] = cell_ff[i];
         if (do_ins) begin
            if (pos[i]) begin
               cell_in[i] = value_ff;
            end else if (after[i] && i > 0) begin
               cell_in[i] = cell_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (do_rm && after[i] && i < Capacity - 1) begin
            cell_in[i] = cell_ff[(i < Capacity - 1) ? i + 1 : i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
      end
   end

   // operation capture and result payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_data.action;
         value_ff  <= req_data.operand_value;
         lt_ff     <= lt_in;
         eq_ff     <= eq_in;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
         for (int i = 0; i < Capacity; i++) begin
            cell_ff[i] <= cell_in[i];
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- rtl/bounded_ordered_list_engine.sv -----
// Top level of the bounded ordered list engine.
//
//  channel   direction  handshake             payload
//  req_      in         req_valid/req_ready   req_type  (action, operand_value)
//  rsp_      out        rsp_valid/rsp_ready   rsp_type  (status, found, entry_count)
//
// In each transaction the accept cycle compares the value with every cell at once
// and registers the result; the apply state then shifts the cells and loads the response.
// A new request is not taken until the previous transaction has committed.
// A held response stalls the update cycle until its slot frees; the next
// request is taken while the last response still waits.
// Reset empties the list at once; cell contents are not cleared.
module bounded_ordered_list_engine import bole_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type cmd;

   bole_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   bole_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   // a captured transaction is never overwritten before its commit
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous transaction open");

   // a pending response is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !cmd.commit)
      else $error("commit while response still held");

   // occupancy never exceeds storage
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.entry_count <= CountW'(Capacity)))
      else $error("entry count beyond capacity");

   // dropped insert only when storage is full
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STS_FULL)
         |-> (rsp_data.entry_count == CountW'(Capacity)))
      else $error("full status with free storage");

endmodule

// ----- verif/bounded_ordered_list_engine_tb.sv -----
// Self-checking testbench for the bounded ordered list engine.
`timescale 1ns / 100ps

module bounded_ordered_list_engine_tb;
   import bole_pkg::*;

   typedef logic signed [ValueW-1:0] word_type;

   localparam int         CLK_HALF    = 4;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         HOLD_CYCLES = 300;
   localparam int         MAX_REPORTS = 10;
   localparam logic [2:0] ACT_UNUSED  = 3'd7;
   localparam word_type   VAL_MAX     = 32'sh7fffffff;
   localparam word_type   VAL_MIN     = 32'sh80000000;

   localparam logic [2:0] INSERT_OPS [3] = '{ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_SORTED_INS};
   localparam logic [2:0] POP_OPS    [2] = '{ACT_POP_FRONT, ACT_POP_BACK};
   localparam logic [2:0] LOOKUP_OPS [2] = '{ACT_REMOVE, ACT_SEARCH};

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // List contents as the engine should hold them, front first
   word_type list_shadow[$];
   // Responses still owed by the engine, oldest first
   rsp_type  pending_rsp[$];

   int      mismatch_count = 0;
   int      cycle_count    = 0;
   int      send_idle_pct  = 0;
   int      rsp_stall_pct  = 0;
   logic    rsp_hold       = 1'b0;
   event    hold_off_go;

   bounded_ordered_list_engine uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #CLK_HALF clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Apply one operation to the shadow list and return the response it owes
   function automatic rsp_type apply_list_op(req_type op);
      rsp_type  res;
      int       pos;
      word_type v;
      v          = op.operand_value;
      res.status = STS_DONE;
      res.found  = 1'b0;
      case (op.action)
         ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_SORTED_INS: begin
            if (list_shadow.size() >= Capacity) begin
               res.status = STS_FULL;
            end else if (op.action == ACT_PUSH_FRONT) begin
               list_shadow.push_front(v);
            end else if (op.action == ACT_PUSH_BACK) begin
               list_shadow.push_back(v);
            end else begin
               // goes ahead of the first entry not smaller than it
               pos = 0;
               while (pos < list_shadow.size() && list_shadow[pos] < v) pos++;
               list_shadow.insert(pos, v);
            end
         end
         ACT_POP_FRONT, ACT_POP_BACK: begin
            if (list_shadow.size() == 0) begin
               res.status = STS_EMPTY;
            end else if (op.action == ACT_POP_FRONT) begin
               void'(list_shadow.pop_front());
            end else begin
               void'(list_shadow.pop_back());
            end
         end
         ACT_REMOVE, ACT_SEARCH: begin
            pos = -1;
            foreach (list_shadow[i]) begin
               if (pos < 0 && list_shadow[i] == v) pos = i;
            end
            if (pos < 0) begin
               res.status = STS_MISS;
            end else begin
               res.found = 1'b1;
               if (op.action == ACT_REMOVE) list_shadow.delete(pos);
            end
         end
         default: ;
      endcase
      res.entry_count = CountW'(list_shadow.size());
      return res;
   endfunction

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $realtime, what);
   endtask

   task automatic check_response(rsp_type got);
      rsp_type want;
      if (pending_rsp.size() == 0) begin
         report_mismatch($sformatf(
            "response with none outstanding: status %0d found %0d count %0d",
            got.status, got.found, got.entry_count));
      end else begin
         want = pending_rsp.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status: expected %0d, got %0d", want.status, got.status));
         if (got.found !== want.found)
            report_mismatch($sformatf("found: expected %0d, got %0d", want.found, got.found));
         if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count: expected %0d, got %0d",
                                      want.entry_count, got.entry_count));
      end
   endtask

   // Response side: check each transaction, then choose next ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_response(rsp_data);
         rsp_ready <= !rsp_hold && ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Long receiver hold-off, counted here
   always begin
      @(hold_off_go);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Offer one operation; valid is left high after acceptance so that a
   // following operation can go back to back
   task automatic send_op(logic [2:0] act, word_type val);
      req_type op;
      bit      lowered;
      lowered = 1'b0;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         if (!lowered) req_valid <= 1'b0;
         lowered = 1'b1;
         @(posedge clock);
      end
      op.action        = act;
      op.operand_value = val;
      pending_rsp.push_back(apply_list_op(op));
      req_valid <= 1'b1;
      req_data  <= op;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering and wait for every outstanding response
   task automatic wait_responses;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic word_type pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return word_type'($urandom_range(0, 16)) - 8;
      if (r < 70 && list_shadow.size() != 0)
         return list_shadow[$urandom_range(0, list_shadow.size() - 1)];
      if (r < 90) return word_type'($urandom);
      return ($urandom_range(0, 1) != 0) ? VAL_MAX : VAL_MIN;
   endfunction

   task automatic send_random_op(int push_bias);
      int         r;
      logic [2:0] act;
      r = $urandom_range(0, 99);
      if (r < 3)              act = ACT_UNUSED;
      else if (r < push_bias) act = INSERT_OPS[$urandom_range(0, 2)];
      else if (r % 5 < 2)     act = POP_OPS[$urandom_range(0, 1)];
      else                    act = LOOKUP_OPS[$urandom_range(0, 1)];
      send_op(act, pick_value());
   endtask

   // Empty-list cases, ordering of equal values, hits and misses, full store
   task automatic test_directed;
      send_op(ACT_POP_FRONT, 0);
      send_op(ACT_POP_BACK, -1);
      send_op(ACT_SEARCH, 5);
      send_op(ACT_REMOVE, 5);
      send_op(ACT_PUSH_FRONT, VAL_MAX);
      send_op(ACT_PUSH_BACK, VAL_MIN);
      send_op(ACT_SORTED_INS, 0);
      send_op(ACT_SORTED_INS, 0);
      send_op(ACT_SORTED_INS, -1);
      send_op(ACT_SEARCH, VAL_MAX);
      send_op(ACT_REMOVE, VAL_MIN);
      send_op(ACT_SEARCH, 12345);
      send_op(ACT_UNUSED, -1);
      while (list_shadow.size() < Capacity) send_op(ACT_PUSH_BACK, word_type'($urandom));
      send_op(ACT_PUSH_FRONT, 1);
      send_op(ACT_SORTED_INS, VAL_MIN);
      send_op(ACT_PUSH_BACK, VAL_MAX);
      wait_responses();
   endtask

   // Random operations, swinging between filling and draining the list
   task automatic test_random(int n, int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < n; i++) send_random_op(((i / 40) % 2 != 0) ? 75 : 30);
      wait_responses();
   endtask

   // Receiver holds off while requests keep coming, so the input stalls
   task automatic test_backpressure;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      -> hold_off_go;
      for (int i = 0; i < 10; i++) send_random_op(60);
      wait_responses();
   endtask

   // Sender pauses until every response is in, then carries on
   task automatic test_pause;
      send_idle_pct = 7;
      rsp_stall_pct = 7;
      for (int i = 0; i < 20; i++) send_random_op(60);
      wait_responses();
      for (int i = 0; i < 20; i++) send_random_op(40);
      wait_responses();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(400, 0, 0);
      test_random(300, 86, 0);
      test_random(300, 0, 86);
      test_random(400, 7, 7);
      test_backpressure();
      test_pause();
      test_random(200, 20, 20);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
